// ----- hdl/spi_pin_to_byte_bridge_assert.svh -----
// Assertion helpers for the SPI pin-to-byte bridge.
`ifndef SPI_PIN_TO_BYTE_BRIDGE_ASSERT_SVH
`define SPI_PIN_TO_BYTE_BRIDGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spb assertion failed");

// Next-cycle implication, checked outside reset.
`define SPB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spb assertion failed");

`endif

// ----- hdl/spb_pkg.sv -----
package spb_pkg;

    localparam int WORD_BITS = 8;
    localparam int CNT_BITS  = $clog2(WORD_BITS);
    localparam int CFG_IDX_BITS = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_BITS-1:0] CFG_CPOL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CPHA = 2'd1;

    // pin event codes; code 3 means nothing and only reports
    typedef enum logic [1:0] {
        CMD_SELECT = 2'd0,
        CMD_CLOCK  = 2'd1,
        CMD_MOSI   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]           command;
        logic                 level;
        logic [WORD_BITS-1:0] reply_byte;
    } t_item;

    typedef struct packed {
        logic cpol;
        logic cpha;
    } t_cfg;

    typedef struct packed {
        logic                 miso_level;
        logic                 select_out;
        logic                 byte_done;
        logic [WORD_BITS-1:0] received_byte;
    } t_result;

endpackage

// ----- hdl/spi_pin_to_byte_bridge.sv -----
// SPI slave front end fed by pin-change words. Each input word names one pin
// (chip select, serial clock or MOSI) and its new level, plus the reply byte
// the attached device wants sent next. While chip select is low, clock edges
// sample MOSI and advance MISO per CPOL/CPHA; the eighth sampled bit emits the
// received byte (tuser = 1) and loads the reply byte for the next transfer.
// Every input word gives exactly one output word carrying the MISO level, the
// relayed chip select and, on completion, the byte. Throughput is one word
// per clock unless the output stalls; a result word passes an input register,
// then the event logic into the output register. Pin state updates as a word
// moves into the output register, so a stalled output only holds the input
// stage. Users must write CPOL/CPHA on the config port while idle (not enforced).
module spi_pin_to_byte_bridge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] level, [8:1] reply_byte, [15:9] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] miso_level, [1] select_out,
                                        // [9:2] received_byte, [15:10] zero
    output logic        m_axis_tuser,   // [0] byte_done
    // config writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [spb_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic        i_cfg_data
);
    import spb_pkg::*;

    `include "spi_pin_to_byte_bridge_assert.svh"

    logic    r_cpol;
    logic    r_cpha;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    t_cfg    cfg;
    logic    advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpol <= 1'b0;
            r_cpha <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CPOL) begin
                r_cpol <= i_cfg_data;
            end
            if (i_cfg_index == CFG_CPHA) begin
                r_cpha <= i_cfg_data;
            end
        end
    end

    assign cfg.cpol = r_cpol;
    assign cfg.cpha = r_cpha;

    // the held word moves on when the output register is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.command    <= s_axis_tuser;
            r_in.level      <= s_axis_tdata[0];
            r_in.reply_byte <= s_axis_tdata[WORD_BITS:1];
        end
    end

    spb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.byte_done;
    assign m_axis_tdata  = {6'd0, r_out.received_byte, r_out.select_out, r_out.miso_level};

    // a byte can only complete while selected
    `SPB_ASSERT_NOW(a_done_selected, m_axis_tvalid && m_axis_tuser, m_axis_tdata[1] == 1'b0)
    // no byte reported means the byte field is cleared
    `SPB_ASSERT_NOW(a_idle_byte_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[9:2] == 8'd0)
    // an empty output register never stalls the input side
    `SPB_ASSERT_NOW(a_ready_when_empty, !r_out_valid, s_axis_tready)
    // a held word that cannot move stays held
    `SPB_ASSERT_NEXT(a_hold_in, r_in_valid && !advance, r_in_valid)

endmodule

// ----- hdl/spb_core.sv -----
module spb_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  spb_pkg::t_item  i_item,
    input  spb_pkg::t_cfg   i_cfg,
    output spb_pkg::t_result o_result
);
    import spb_pkg::*;

    logic                 r_sel, n_sel;
    logic                 r_clk, n_clk;
    logic                 r_mosi, n_mosi;
    logic                 r_miso, n_miso;
    logic [WORD_BITS-1:0] r_rx, n_rx;
    logic [WORD_BITS-1:0] r_tx, n_tx;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 done;
    logic [WORD_BITS-1:0] got;
    logic [WORD_BITS-1:0] rx_or;
    logic                 is_edge;
    logic                 leading;

    always_comb begin
        n_sel  = r_sel;
        n_clk  = r_clk;
        n_mosi = r_mosi;
        n_miso = r_miso;
        n_rx   = r_rx;
        n_tx   = r_tx;
        n_cnt  = r_cnt;
        done   = 1'b0;
        got    = '0;
        rx_or   = r_rx | {{(WORD_BITS-1){1'b0}}, r_mosi};
        is_edge = (r_sel == 1'b0) && (r_clk != i_item.level);
        leading = (i_item.level != i_cfg.cpol);
        case (t_cmd'(i_item.command))
            CMD_SELECT: begin
                n_sel  = i_item.level;
                n_miso = r_tx[WORD_BITS-1];
                n_clk  = i_cfg.cpol;
            end
            CMD_CLOCK: begin
                if (is_edge) begin
                    n_clk = i_item.level;
                    if (leading) begin
                        if (i_cfg.cpha) begin
                            n_miso = r_tx[WORD_BITS-1];
                        end else begin
                            n_rx = rx_or;
                        end
                    end else begin
                        // trailing edge: sample for CPHA 1, then count and shift, or finish the byte on its last bit
                        if (r_cnt == CNT_BITS'(WORD_BITS - 1)) begin
                            done  = 1'b1;
                            got   = i_cfg.cpha ? rx_or : r_rx;
                            n_tx  = i_item.reply_byte;
                            n_rx  = '0;
                            n_cnt = '0;
                        end else begin
                            n_rx  = {(i_cfg.cpha ? rx_or[WORD_BITS-2:0] : r_rx[WORD_BITS-2:0]),
                                     1'b0};
                            n_tx  = {r_tx[WORD_BITS-2:0], 1'b0};
                            n_cnt = r_cnt + 1'b1;
                        end
                        if (!i_cfg.cpha) begin
                            n_miso = n_tx[WORD_BITS-1];
                        end
                    end
                end
            end
            CMD_MOSI: begin
                n_mosi = i_item.level;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.miso_level    = n_miso;
        o_result.select_out    = n_sel;
        o_result.byte_done     = done;
        o_result.received_byte = got;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= 1'b1;
            r_clk  <= 1'b1;
            r_mosi <= 1'b1;
            r_miso <= 1'b0;
            r_rx   <= '0;
            r_tx   <= '0;
            r_cnt  <= '0;
        end else if (i_fire) begin
            r_sel  <= n_sel;
            r_clk  <= n_clk;
            r_mosi <= n_mosi;
            r_miso <= n_miso;
            r_rx   <= n_rx;
            r_tx   <= n_tx;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ----- verif/tb_spi_pin_to_byte_bridge.sv -----
module tb_spi_pin_to_byte_bridge;

    timeunit 1ns;
    timeprecision 1ps;

    import spb_pkg::*;

    // command code 3 is not an event, the block only reports its outputs
    localparam logic [1:0] CMD_NONE = 2'd3;
    // index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    localparam int PHASE_WORDS = 300;
    localparam int NUM_PHASES  = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;     // comfortably above the two-stage pipeline

    // Pin-level model of the SPI slave plus the queue of results it has
    // worked out but not yet seen on the output.
    class spi_pin_tracker;
        logic            cpol;
        logic            cpha;
        logic            sel_lvl;
        logic            clk_lvl;
        logic            mosi_lvl;
        logic            miso_q;
        logic [7:0]      rx_sr;
        logic [7:0]      tx_sr;
        logic [3:0]      bit_cnt;
        t_result         pending_results[$];
        int unsigned     mismatches;

        function new();
            cpol       = 1'b0;
            cpha       = 1'b0;
            sel_lvl    = 1'b1;
            clk_lvl    = 1'b1;
            mosi_lvl   = 1'b1;
            miso_q     = 1'b0;
            rx_sr      = 8'd0;
            tx_sr      = 8'd0;
            bit_cnt    = 4'd0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic d);
            if (idx == CFG_CPOL) begin
                cpol = d;
            end else if (idx == CFG_CPHA) begin
                cpha = d;
            end
        endfunction

        // one accepted pin-change word -> one expected result word
        function void note_pin_event(logic [1:0] cmd, logic lvl, logic [7:0] reply);
            t_result r;
            r = '0;
            case (cmd)
                CMD_SELECT: begin
                    sel_lvl = lvl;
                    miso_q  = tx_sr[7];
                    clk_lvl = cpol;
                end
                CMD_CLOCK: begin
                    // ignored while deselected or when the level did not move
                    if (!sel_lvl && clk_lvl != lvl) begin
                        clk_lvl = lvl;
                        if (lvl != cpol) begin
                            // leading edge
                            if (cpha) miso_q = tx_sr[7];
                            else      rx_sr[0] = rx_sr[0] | mosi_lvl;
                        end else begin
                            // trailing edge
                            if (cpha) rx_sr[0] = rx_sr[0] | mosi_lvl;
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt >= 4'd8) begin
                                r.byte_done     = 1'b1;
                                r.received_byte = rx_sr;
                                tx_sr   = reply;
                                rx_sr   = 8'd0;
                                bit_cnt = 4'd0;
                            end else begin
                                rx_sr = rx_sr << 1;
                                tx_sr = tx_sr << 1;
                            end
                            // CPHA 0 drives after the shift or reload
                            if (!cpha) miso_q = tx_sr[7];
                        end
                    end
                end
                CMD_MOSI: mosi_lvl = lvl;
                default: ;
            endcase
            r.miso_level = miso_q;
            r.select_out = sel_lvl;
            pending_results.push_back(r);
        endfunction

        // fields shown as miso/sel/done/byte
        function void report(string what, t_result exp_r, t_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s exp %0b/%0b/%0b/%02h got %0b/%0b/%0b/%02h",
                         $realtime, what, exp_r.miso_level, exp_r.select_out,
                         exp_r.byte_done, exp_r.received_byte, got.miso_level,
                         got.select_out, got.byte_done, got.received_byte);
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending_results.size() == 0) begin
                report("unexpected word", '0, got);
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.miso_level !== exp_r.miso_level || got.select_out !== exp_r.select_out ||
                got.byte_done !== exp_r.byte_done ||
                got.received_byte !== exp_r.received_byte) begin
                report("mismatch", exp_r, got);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic        i_cfg_data = 1'b0;

    spi_pin_tracker tracker = new();

    bit          calm = 1'b0;       // set for a stretch with no idling on either side
    logic        cur_cpol = 1'b0;   // clock polarity the stimulus is shaped for
    int unsigned words_sent = 0;
    int unsigned cycle_cnt = 0;

    spi_pin_to_byte_bridge dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // run time guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side backpressure, about a quarter of cycles stalled
    always @(posedge i_clk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    // Handshake monitor. Values read here are the ones settled before the
    // edge, so drivers updating at the same edge do not disturb them.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.set_reg(i_cfg_index, i_cfg_data);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.miso_level    = m_axis_tdata[0];
                got.select_out    = m_axis_tdata[1];
                got.received_byte = m_axis_tdata[9:2];
                got.byte_done     = m_axis_tuser;
                tracker.check_result(got);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.note_pin_event(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[8:1]);
            end
        end
    end

    // one pin-change word; returns at the edge that accepted it
    task automatic send_word(logic [1:0] cmd, logic lvl, logic [7:0] reply);
        while (!calm && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, reply, lvl};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_noise();
        send_word(2'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));
    endtask

    // drop valid and let every outstanding result come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(logic pol, logic pha);
        write_reg(CFG_CPOL, pol);
        write_reg(CFG_CPHA, pha);
        cur_cpol = pol;
    endtask

    // A select-framed run of one to three bytes with random content. Now and
    // then a stray word is slipped in, or the frame is cut short.
    task automatic run_frame();
        int nbytes;
        nbytes = $urandom_range(1, 3);
        send_word(CMD_SELECT, 1'b0, 8'($urandom));
        for (int b = 0; b < nbytes; b++) begin
            for (int k = 0; k < 8; k++) begin
                if ($urandom_range(0, 1)) send_word(CMD_MOSI, 1'($urandom), 8'($urandom));
                if ($urandom_range(0, 99) < 4) send_noise();
                send_word(CMD_CLOCK, ~cur_cpol, 8'($urandom));
                // MOSI moving between the edges matters for CPHA 1
                if ($urandom_range(0, 99) < 15) begin
                    send_word(CMD_MOSI, 1'($urandom), 8'($urandom));
                end
                send_word(CMD_CLOCK, cur_cpol, 8'($urandom));
                if ($urandom_range(0, 199) == 0) begin
                    send_word(CMD_SELECT, 1'b1, 8'($urandom));
                    return;
                end
            end
        end
        send_word(CMD_SELECT, 1'b1, 8'($urandom));
    endtask

    initial begin
        logic pol;
        logic pha;
        int target;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_mode(1'b0, 1'b0);

        // directed: idle reports, ignored clocks, then one full byte in mode 0
        send_word(CMD_NONE, 1'b1, 8'hFF);
        send_word(CMD_CLOCK, 1'b0, 8'hFF);     // deselected, ignored
        send_word(CMD_MOSI, 1'b0, 8'h00);
        send_word(CMD_MOSI, 1'b1, 8'hFF);
        send_word(CMD_SELECT, 1'b0, 8'h00);
        send_word(CMD_CLOCK, 1'b0, 8'h00);     // level unchanged, ignored
        for (int k = 0; k < 8; k++) begin
            if (k == 4) send_word(CMD_MOSI, 1'b0, 8'h00);
            send_word(CMD_CLOCK, 1'b1, 8'h00);
            send_word(CMD_CLOCK, 1'b0, (k == 7) ? 8'hFF : 8'h00);
        end
        send_word(CMD_SELECT, 1'b1, 8'h00);
        send_word(CMD_NONE, 1'b0, 8'h00);
        drain();

        // random phases: all four modes, then random ones
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 4) begin
                pol = p[1];
                pha = p[0];
            end else begin
                pol = 1'($urandom);
                pha = 1'($urandom);
            end
            set_mode(pol, pha);
            if (p == 3) write_reg(CFG_UNUSED, 1'b1);
            calm = (p == 1);
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                if ($urandom_range(0, 99) < 85) run_frame();
                else send_noise();
            end
            drain();
            calm = 1'b0;
        end

        if (tracker.pending() != 0) tracker.mismatches++;
        if (tracker.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
